[rtl/core/usi_pkg.sv]
// ----------------------------------------------------------------------------
// usi_pkg
// Shared widths, weights and register codes of the uniform Simpson integrator.
// ----------------------------------------------------------------------------
`default_nettype none

package usi_pkg;

  // payload and state widths
  localparam int unsigned SAMPLE_W   = 32;
  localparam int unsigned RESULT_W   = 64;
  localparam int unsigned SUM_W      = 50;
  localparam int unsigned STEP_W     = 32;
  localparam int unsigned NPTS_W     = 13;
  localparam int unsigned WEIGHT_W   = 6;

  localparam int unsigned MAX_POINTS_DEF = 4096;

  // configuration port
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic REG_NUM_POINTS = 1'b0;
  localparam logic REG_STEP_H     = 1'b1;

  localparam logic [NPTS_W-1:0] NUM_POINTS_RST = 13'd3;
  localparam logic [STEP_W-1:0] STEP_H_RST     = 32'd65536;

  // weights over the common denominator 24
  localparam logic [WEIGHT_W-1:0] W_SINGLE      = 6'd16;
  localparam logic [WEIGHT_W-1:0] W_SIMP_END    = 6'd8;
  localparam logic [WEIGHT_W-1:0] W_SIMP_ODD    = 6'd32;
  localparam logic [WEIGHT_W-1:0] W_SIMP_EVEN   = 6'd16;
  localparam logic [WEIGHT_W-1:0] W_TWO         = 6'd12;
  localparam logic [WEIGHT_W-1:0] W_FOUR_END    = 6'd9;
  localparam logic [WEIGHT_W-1:0] W_FOUR_IN     = 6'd27;
  localparam logic [WEIGHT_W-1:0] W_HH_EDGE0    = 6'd9;
  localparam logic [WEIGHT_W-1:0] W_HH_EDGE1    = 6'd28;
  localparam logic [WEIGHT_W-1:0] W_HH_EDGE2    = 6'd23;
  localparam logic [WEIGHT_W-1:0] W_HH_INNER    = 6'd24;

  // final scaling: product split and divide by 24 = 2^3 * 3, with the
  // Q16.16 step adding another 2^14
  localparam int unsigned SPLIT_W    = 32;
  localparam int unsigned PROD_SHIFT = 17;

  // divide by 3, one 16-bit digit per stage
  localparam int unsigned DIG_W       = 16;
  localparam int unsigned DIV_DIGITS  = RESULT_W / DIG_W;
  localparam int unsigned RECIP_W     = 21;
  localparam int unsigned RECIP_SHIFT = 20;
  localparam logic [RECIP_W-1:0] RECIP_3 = 21'd349526;

endpackage

`default_nettype wire

[rtl/core/usi_sample_if.sv]
// ----------------------------------------------------------------------------
// usi_sample_if
// Valid/ready channel carrying one signed Q16.16 sample per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface usi_sample_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [usi_pkg::SAMPLE_W-1:0]  sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

[rtl/core/usi_result_if.sv]
// ----------------------------------------------------------------------------
// usi_result_if
// Valid/ready channel carrying one signed Q46.18 integral per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface usi_result_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [usi_pkg::RESULT_W-1:0]  integral;

  modport source (output valid, output integral, input ready);
  modport sink   (input valid, input integral, output ready);
endinterface

`default_nettype wire

[rtl/core/uniform_simpson_hh_integrator_core.sv]
// ----------------------------------------------------------------------------
// uniform_simpson_hh_integrator_core
// Weighted running sum of equally spaced samples with Simpson or end-corrected
// weights, scaled by the step and divided by 24 at the end of each run.
// ----------------------------------------------------------------------------
// Throughput: one sample per cycle while the result side does not stall.
// After the edge that accepts its last sample, the integral of a run passes
// through the input register, accumulate, sign/magnitude, two multipliers,
// product align, four divide-by-3 digit stages and the output register.
// A waiting result holds the pipeline and drops sample ready only once the
// next result reaches the last divide stage.
// Reset clears the accumulator, the sample index, all valid bits, and loads
// num_points = 3 and step_h = 1.0.
`default_nettype none

module uniform_simpson_hh_integrator_core #(
  parameter int unsigned MAX_POINTS = usi_pkg::MAX_POINTS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [usi_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [usi_pkg::APB_DATA_W-1:0]    pwdata,
  output logic      [usi_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                   pready,
  usi_sample_if.sink                             sample_i,
  usi_result_if.source                           result_o
);

  localparam int unsigned CNT_W   = $clog2(MAX_POINTS + 1);
  localparam int unsigned IDX_W   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned SAMPLE_W = usi_pkg::SAMPLE_W;
  localparam int unsigned RESULT_W = usi_pkg::RESULT_W;
  localparam int unsigned SUM_W    = usi_pkg::SUM_W;
  localparam int unsigned STEP_W   = usi_pkg::STEP_W;
  localparam int unsigned WEIGHT_W = usi_pkg::WEIGHT_W;
  localparam int unsigned TERM_W   = SAMPLE_W + WEIGHT_W + 1;
  localparam int unsigned SPLIT_W  = usi_pkg::SPLIT_W;
  localparam int unsigned HI_W     = SUM_W - SPLIT_W;
  localparam int unsigned PLO_W    = SPLIT_W + STEP_W;
  localparam int unsigned PHI_W    = HI_W + STEP_W;
  localparam int unsigned ALIGN_W  = SPLIT_W - usi_pkg::PROD_SHIFT;
  localparam int unsigned DIG_W    = usi_pkg::DIG_W;
  localparam int unsigned DIGITS   = usi_pkg::DIV_DIGITS;
  localparam int unsigned X_W      = DIG_W + 2;
  localparam int unsigned XP_W     = X_W + usi_pkg::RECIP_W;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [usi_pkg::NPTS_W-1:0] num_points_q;
  logic [STEP_W-1:0]          step_h_q;
  logic                       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_points_q <= usi_pkg::NUM_POINTS_RST;
      step_h_q     <= usi_pkg::STEP_H_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        usi_pkg::REG_NUM_POINTS: num_points_q <= pwdata[usi_pkg::NPTS_W-1:0];
        usi_pkg::REG_STEP_H:     step_h_q     <= pwdata[STEP_W-1:0];
        default:                 num_points_q <= num_points_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      usi_pkg::REG_NUM_POINTS: prdata = usi_pkg::APB_DATA_W'(num_points_q);
      usi_pkg::REG_STEP_H:     prdata = usi_pkg::APB_DATA_W'(step_h_q);
      default:                 prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // pipeline advance: everything moves unless a waiting result would be
  // overwritten by the next one
  // --------------------------------------------------------------------------
  logic out_valid_q;
  logic [DIGITS:0] div_valid_q;
  logic en;
  logic accept;

  assign en             = !out_valid_q || result_o.ready || !div_valid_q[DIGITS];
  assign sample_i.ready = en;
  assign accept         = sample_i.valid && en;

  // --------------------------------------------------------------------------
  // position and weight of the incoming sample
  // --------------------------------------------------------------------------
  logic [IDX_W-1:0]    idx_q;
  logic [CNT_W-1:0]    n_eff;
  logic [CNT_W-1:0]    n_m1;
  logic [CNT_W-1:0]    idx_ext;
  logic [CNT_W-1:0]    i_eff;
  logic [CNT_W-1:0]    r_eff;
  logic                is_last;
  logic                at_end0;
  logic [WEIGHT_W-1:0] weight;

  always_comb begin
    if (num_points_q == '0) begin
      n_eff = CNT_W'(1);
    end else if (32'(num_points_q) > 32'(MAX_POINTS)) begin
      n_eff = CNT_W'(MAX_POINTS);
    end else begin
      n_eff = CNT_W'(num_points_q);
    end
  end

  assign n_m1    = n_eff - CNT_W'(1);
  assign idx_ext = CNT_W'(idx_q);
  assign is_last = idx_ext >= n_m1;
  assign i_eff   = is_last ? n_m1 : idx_ext;
  assign r_eff   = n_m1 - i_eff;
  assign at_end0 = (i_eff == '0) || (r_eff == '0);

  always_comb begin
    priority if (n_eff[0]) begin
      priority if (n_eff == CNT_W'(1)) begin
        weight = usi_pkg::W_SINGLE;
      end else if (at_end0) begin
        weight = usi_pkg::W_SIMP_END;
      end else if (i_eff[0]) begin
        weight = usi_pkg::W_SIMP_ODD;
      end else begin
        weight = usi_pkg::W_SIMP_EVEN;
      end
    end else if (n_eff == CNT_W'(2)) begin
      weight = usi_pkg::W_TWO;
    end else if (n_eff == CNT_W'(4)) begin
      weight = at_end0 ? usi_pkg::W_FOUR_END : usi_pkg::W_FOUR_IN;
    end else if (at_end0) begin
      weight = usi_pkg::W_HH_EDGE0;
    end else if ((i_eff == CNT_W'(1)) || (r_eff == CNT_W'(1))) begin
      weight = usi_pkg::W_HH_EDGE1;
    end else if ((i_eff == CNT_W'(2)) || (r_eff == CNT_W'(2))) begin
      weight = usi_pkg::W_HH_EDGE2;
    end else begin
      weight = usi_pkg::W_HH_INNER;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (accept) begin
      idx_q <= is_last ? '0 : idx_q + IDX_W'(1);
    end
  end

  // --------------------------------------------------------------------------
  // input register and accumulator
  // --------------------------------------------------------------------------
  logic                       a_valid_q;
  logic                       a_last_q;
  logic signed [SAMPLE_W-1:0] a_sample_q;
  logic [WEIGHT_W-1:0]        a_weight_q;
  logic signed [TERM_W-1:0]   term;
  logic [SUM_W-1:0]           sum_q;
  logic [SUM_W-1:0]           sum_next;

  assign term     = a_sample_q * $signed({1'b0, a_weight_q});
  assign sum_next = sum_q + {{(SUM_W-TERM_W){term[TERM_W-1]}}, term};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      sum_q     <= '0;
    end else if (en) begin
      a_valid_q <= accept;
      if (a_valid_q) begin
        sum_q <= a_last_q ? '0 : sum_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_last_q   <= is_last;
      a_sample_q <= sample_i.sample;
      a_weight_q <= weight;
    end
  end

  // --------------------------------------------------------------------------
  // finish: magnitude, scale by step, divide by 2^17 and by 3, saturate
  // --------------------------------------------------------------------------
  logic                    f1_valid_q;
  logic [SUM_W-1:0]        f1_sum_q;
  logic                    f2_valid_q;
  logic                    f2_neg_q;
  logic [SUM_W-1:0]        f2_mag_q;
  logic                    f3_valid_q;
  logic                    f3_neg_q;
  logic [PLO_W-1:0]        p_lo_q;
  logic [PHI_W-1:0]        p_hi_q;
  logic [DIGITS:0]         div_neg_q;
  logic [RESULT_W-1:0]     div_w_q [DIGITS+1];
  logic [1:0]              div_r_q [DIGITS];
  logic [RESULT_W-1:0]     div_w_next [DIGITS];
  logic [1:0]              div_r_next [DIGITS];
  logic [X_W-1:0]          div_x [DIGITS];
  logic [XP_W-1:0]         div_xp [DIGITS];
  logic [DIG_W-1:0]        div_qd [DIGITS];
  logic [X_W-1:0]          div_rem [DIGITS];
  logic [RESULT_W-1:0]     aligned;
  logic [RESULT_W-1:0]     quot;
  logic [RESULT_W-1:0]     sat;
  logic [RESULT_W-1:0]     out_q;

  assign aligned = RESULT_W'({p_hi_q, {ALIGN_W{1'b0}}})
                 + RESULT_W'(p_lo_q >> usi_pkg::PROD_SHIFT);

  // most significant digit first; each remainder stays below 3
  always_comb begin
    for (int j = 0; j < DIGITS; j++) begin
      div_x[j]   = {div_r_q[j], div_w_q[j][(DIGITS-1-j)*DIG_W +: DIG_W]};
      div_xp[j]  = XP_W'(div_x[j]) * XP_W'(usi_pkg::RECIP_3);
      div_qd[j]  = div_xp[j][usi_pkg::RECIP_SHIFT +: DIG_W];
      div_rem[j] = div_x[j] - X_W'({div_qd[j], 1'b0}) - X_W'(div_qd[j]);
      div_r_next[j] = div_rem[j][1:0];
      div_w_next[j] = div_w_q[j];
      div_w_next[j][(DIGITS-1-j)*DIG_W +: DIG_W] = div_qd[j];
    end
  end

  assign quot = div_w_q[DIGITS];

  always_comb begin
    if (div_neg_q[DIGITS]) begin
      sat = quot[RESULT_W-1] ? {1'b1, {(RESULT_W-1){1'b0}}} : RESULT_W'(0) - quot;
    end else begin
      sat = quot[RESULT_W-1] ? {1'b0, {(RESULT_W-1){1'b1}}} : quot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q  <= 1'b0;
      f2_valid_q  <= 1'b0;
      f3_valid_q  <= 1'b0;
      div_valid_q <= '0;
    end else if (en) begin
      f1_valid_q  <= a_valid_q && a_last_q;
      f2_valid_q  <= f1_valid_q;
      f3_valid_q  <= f2_valid_q;
      div_valid_q <= {div_valid_q[DIGITS-1:0], f3_valid_q};
    end
  end

  // output register holds a waiting result while the pipeline keeps moving
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en && div_valid_q[DIGITS]) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_sum_q   <= sum_next;
      f2_neg_q   <= f1_sum_q[SUM_W-1];
      f2_mag_q   <= f1_sum_q[SUM_W-1] ? SUM_W'(0) - f1_sum_q : f1_sum_q;
      f3_neg_q   <= f2_neg_q;
      p_lo_q     <= PLO_W'(f2_mag_q[SPLIT_W-1:0]) * PLO_W'(step_h_q);
      p_hi_q     <= PHI_W'(f2_mag_q[SUM_W-1:SPLIT_W]) * PHI_W'(step_h_q);
      div_neg_q  <= {div_neg_q[DIGITS-1:0], f3_neg_q};
      div_w_q[0] <= aligned;
      div_r_q[0] <= 2'b00;
      for (int j = 0; j < DIGITS; j++) begin
        div_w_q[j+1] <= div_w_next[j];
        if (j + 1 < DIGITS) begin
          div_r_q[j+1] <= div_r_next[j];
        end
      end
      if (div_valid_q[DIGITS]) begin
        out_q <= sat;
      end
    end
  end

  assign result_o.valid    = out_valid_q;
  assign result_o.integral = out_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_sum_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && a_valid_q && a_last_q |=> sum_q == '0)
    else $error("accumulator not cleared after the last sample of a run");

  a_idx_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && is_last |=> idx_q == '0)
    else $error("sample index not cleared after the last sample of a run");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sample_i.ready |-> result_o.valid && !result_o.ready)
    else $error("sample side stalled without a waiting result");

endmodule

`default_nettype wire
